@@ rtl/tapt_pkg.sv @@
// Shared types, constants and the control program of the three-axis thrust unit.
// Used by tapt_qmul and three_axis_pid_thrust_unit; depends on nothing else.
package tapt_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_N     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int OPA_W     = 33;
    localparam int PROD_W    = 48;
    localparam int ACC_W     = 50;
    localparam int STEP_W    = 4;
    localparam int AXIS_N    = 3;
    localparam int AXIS_W    = 2;
    localparam int AXES_DEF  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MASS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
        31'd655, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd65536, 31'd642690
    };

    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;

    localparam logic [STEP_W-1:0] ST_START   = 4'd0;
    localparam logic [STEP_W-1:0] ST_FORCE   = 4'd9;
    localparam logic [STEP_W-1:0] ST_UNCTRL  = 4'd14;
    localparam logic [STEP_W-1:0] ST_FINISH  = 4'd15;

    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] S32_MIN = -ACC_W'(64'sd2147483648);

    typedef enum logic [2:0] {
        A_E, A_EV, A_INTEG, A_ACCEL, A_MASS
    } t_asel;

    typedef enum logic [2:0] {
        B_DT, B_KP, B_KI, B_KD, B_MASS, B_GRAV
    } t_bsel;

    typedef enum logic [2:0] {
        ACC_NOP, ACC_CLR, ACC_LOADI, ACC_LOADP, ACC_ADD, ACC_SUBZ
    } t_accop;

    typedef enum logic [1:0] {
        WR_NONE, WR_INTEG, WR_ACCEL, WR_FORCE
    } t_wrop;

    typedef enum logic [2:0] {
        J_NONE, J_UNCTRL, J_ALWAYS, J_AXIS, J_FINISH
    } t_jmp;

    typedef struct packed {
        t_asel              a_sel;
        t_bsel              b_sel;
        t_accop             acc_op;
        t_wrop              wr_op;
        t_jmp               jmp;
        logic [STEP_W-1:0]  target;
    } t_uop;

    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{A_E, B_DT, ACC_NOP, WR_NONE, J_NONE, ST_START};
        case (step)
            4'd0:  u = '{A_E,     B_DT,   ACC_CLR,   WR_NONE,  J_UNCTRL, ST_UNCTRL};
            4'd1:  u = '{A_E,     B_DT,   ACC_LOADI, WR_NONE,  J_NONE,   ST_START};
            4'd2:  u = '{A_E,     B_KP,   ACC_NOP,   WR_NONE,  J_NONE,   ST_START};
            4'd3:  u = '{A_EV,    B_KD,   ACC_ADD,   WR_NONE,  J_NONE,   ST_START};
            4'd4:  u = '{A_E,     B_DT,   ACC_LOADP, WR_INTEG, J_NONE,   ST_START};
            4'd5:  u = '{A_INTEG, B_KI,   ACC_ADD,   WR_NONE,  J_NONE,   ST_START};
            4'd6:  u = '{A_E,     B_DT,   ACC_NOP,   WR_NONE,  J_NONE,   ST_START};
            4'd7:  u = '{A_E,     B_DT,   ACC_ADD,   WR_NONE,  J_NONE,   ST_START};
            4'd8:  u = '{A_E,     B_DT,   ACC_CLR,   WR_ACCEL, J_NONE,   ST_START};
            4'd9:  u = '{A_ACCEL, B_MASS, ACC_NOP,   WR_NONE,  J_NONE,   ST_START};
            4'd10: u = '{A_MASS,  B_GRAV, ACC_NOP,   WR_NONE,  J_NONE,   ST_START};
            4'd11: u = '{A_E,     B_DT,   ACC_ADD,   WR_NONE,  J_NONE,   ST_START};
            4'd12: u = '{A_E,     B_DT,   ACC_SUBZ,  WR_NONE,  J_NONE,   ST_START};
            4'd13: u = '{A_E,     B_DT,   ACC_NOP,   WR_FORCE, J_AXIS,   ST_START};
            4'd14: u = '{A_E,     B_DT,   ACC_NOP,   WR_ACCEL, J_ALWAYS, ST_FORCE};
            4'd15: u = '{A_E,     B_DT,   ACC_NOP,   WR_NONE,  J_FINISH, ST_START};
            default: u = '{A_E,   B_DT,   ACC_NOP,   WR_NONE,  J_NONE,   ST_START};
        endcase
        return u;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] v,
        input logic [CFG_W-1:0]        lim
    );
        logic signed [ACC_W-1:0] l;
        logic signed [ACC_W-1:0] nl;
        logic signed [ACC_W-1:0] r;
        l  = signed'({{(ACC_W-CFG_W){1'b0}}, lim});
        nl = -l;
        if (v > l) begin
            r = l;
        end else if (v < nl) begin
            r = nl;
        end else begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX;
        end else if (v < S32_MIN) begin
            r = S32_MIN;
        end else begin
            r = v;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/tapt_qmul.sv @@
// Two-stage Q16.16 multiplier: signed operand by unsigned operand, rounded toward zero.
// Splits the magnitude into two partial products; uses tapt_pkg widths.
module tapt_qmul (
    input  logic                                 i_clk,
    input  logic signed [tapt_pkg::OPA_W-1:0]    i_a,
    input  logic        [tapt_pkg::CFG_W-1:0]    i_b,
    output logic signed [tapt_pkg::PROD_W-1:0]   o_p
);

    localparam int LO_W  = 17;
    localparam int HI_W  = tapt_pkg::OPA_W - LO_W;
    localparam int PL_W  = LO_W + tapt_pkg::CFG_W;
    localparam int PH_W  = HI_W + tapt_pkg::CFG_W;
    localparam int FULL_W = PH_W + LO_W;

    logic [tapt_pkg::OPA_W-1:0]      mag;
    logic [PL_W-1:0]                 n_pl;
    logic [PH_W-1:0]                 n_ph;
    logic [PL_W-1:0]                 r_pl;
    logic [PH_W-1:0]                 r_ph;
    logic                            r_neg;
    logic [FULL_W-1:0]               full;
    logic [tapt_pkg::PROD_W-1:0]     mag_p;
    logic signed [tapt_pkg::PROD_W-1:0] n_p;
    logic signed [tapt_pkg::PROD_W-1:0] r_p;

    always_comb begin
        mag  = i_a[tapt_pkg::OPA_W-1] ? (~i_a + 1'b1) : i_a;
        n_pl = PL_W'(mag[LO_W-1:0]) * PL_W'(i_b);
        n_ph = PH_W'(mag[tapt_pkg::OPA_W-1:LO_W]) * PH_W'(i_b);
        full = {r_ph, {LO_W{1'b0}}} + FULL_W'(r_pl);
        mag_p = full[FULL_W-1:16];
        n_p  = r_neg ? -signed'(mag_p) : signed'(mag_p);
    end

    always_ff @(posedge i_clk) begin
        r_pl  <= n_pl;
        r_ph  <= n_ph;
        r_neg <= i_a[tapt_pkg::OPA_W-1];
        r_p   <= n_p;
    end

    assign o_p = r_p;

endmodule

@@ rtl/three_axis_pid_thrust_unit.sv @@
// Top level of the three-axis PID thrust unit: register file, sequencer and datapath.
// Depends on tapt_pkg and tapt_qmul.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready carrying position, velocity and
//   target of three axes plus a flag that zeroes the integrators first.
//   Results leave on o_out_valid / i_out_ready as three saturated forces.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   taken at any edge with i_cfg_we high; write only while idle.
// Sequence:
//   A request is worked by a 16-word control program driving one shared
//   two-stage multiplier: steps 0 to 13 run for each controlled axis,
//   steps 0, 14 and 9 to 13 for each uncontrolled axis, then the
//   finishing step 15 loads the result. o_in_ready stays low while a
//   request is worked, so no new request is taken until it has finished.
// Reset:
//   Restores register defaults, zeroes integrators, empties the output.
// Stall:
//   A finished result waits in the output register; the next request may
//   be taken and worked meanwhile, and its finishing step holds until the
//   output register is free.
module three_axis_pid_thrust_unit #(
    parameter int AXES = tapt_pkg::AXES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [tapt_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [tapt_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_pos_x,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_pos_y,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_pos_z,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_vel_x,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_vel_y,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_vel_z,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_goal_x,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_goal_y,
    input  logic signed [tapt_pkg::DATA_W-1:0]      i_goal_z,
    input  logic                                    i_clear_integrators,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [tapt_pkg::DATA_W-1:0]      o_force_x,
    output logic signed [tapt_pkg::DATA_W-1:0]      o_force_y,
    output logic signed [tapt_pkg::DATA_W-1:0]      o_force_z
);

    localparam logic [tapt_pkg::AXIS_W-1:0] AXES_LIM = tapt_pkg::AXIS_W'(AXES);

    logic                                   r_busy;
    logic                                   n_busy;
    logic [tapt_pkg::STEP_W-1:0]            r_step;
    logic [tapt_pkg::STEP_W-1:0]            n_step;
    logic [tapt_pkg::AXIS_W-1:0]            r_axis;
    logic [tapt_pkg::AXIS_W-1:0]            n_axis;
    logic                                   r_out_valid;
    logic                                   n_out_valid;
    logic                                   accept;
    logic                                   load_out;
    tapt_pkg::t_uop                         uop;

    logic [tapt_pkg::CFG_W-1:0]             r_cfg   [tapt_pkg::CFG_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_integ [tapt_pkg::AXIS_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_pos   [tapt_pkg::AXIS_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_vel   [tapt_pkg::AXIS_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_goal  [tapt_pkg::AXIS_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_res   [tapt_pkg::AXIS_N];
    logic signed [tapt_pkg::DATA_W-1:0]     r_accel;
    logic signed [tapt_pkg::ACC_W-1:0]      r_acc;
    logic signed [tapt_pkg::ACC_W-1:0]      n_acc;
    logic signed [tapt_pkg::DATA_W-1:0]     r_force_x;
    logic signed [tapt_pkg::DATA_W-1:0]     r_force_y;
    logic signed [tapt_pkg::DATA_W-1:0]     r_force_z;

    logic signed [tapt_pkg::OPA_W-1:0]      opa;
    logic        [tapt_pkg::CFG_W-1:0]      opb;
    logic signed [tapt_pkg::PROD_W-1:0]     prod;
    logic signed [tapt_pkg::ACC_W-1:0]      prod_x;

    assign accept     = i_in_valid && !r_busy;
    assign o_in_ready = !r_busy;
    assign uop        = tapt_pkg::ucode(r_step);

    always_comb begin
        case (uop.a_sel)
            tapt_pkg::A_E:     opa = tapt_pkg::OPA_W'(r_goal[r_axis])
                                     - tapt_pkg::OPA_W'(r_pos[r_axis]);
            tapt_pkg::A_EV:    opa = -tapt_pkg::OPA_W'(r_vel[r_axis]);
            tapt_pkg::A_INTEG: opa = tapt_pkg::OPA_W'(r_integ[r_axis]);
            tapt_pkg::A_ACCEL: opa = tapt_pkg::OPA_W'(r_accel);
            tapt_pkg::A_MASS:  opa = signed'({2'b00, r_cfg[tapt_pkg::REG_MASS]});
            default:           opa = '0;
        endcase
        case (uop.b_sel)
            tapt_pkg::B_DT:   opb = r_cfg[tapt_pkg::REG_STEP_TIME];
            tapt_pkg::B_KP:   opb = r_cfg[tapt_pkg::REG_GAIN_P];
            tapt_pkg::B_KI:   opb = r_cfg[tapt_pkg::REG_GAIN_I];
            tapt_pkg::B_KD:   opb = r_cfg[tapt_pkg::REG_GAIN_D];
            tapt_pkg::B_MASS: opb = r_cfg[tapt_pkg::REG_MASS];
            tapt_pkg::B_GRAV: opb = r_cfg[tapt_pkg::REG_GRAVITY];
            default:          opb = '0;
        endcase
    end

    tapt_qmul u_qmul (
        .i_clk (i_clk),
        .i_a   (opa),
        .i_b   (opb),
        .o_p   (prod)
    );

    assign prod_x = tapt_pkg::ACC_W'(prod);

    always_comb begin
        case (uop.acc_op)
            tapt_pkg::ACC_CLR:   n_acc = '0;
            tapt_pkg::ACC_LOADI: n_acc = tapt_pkg::ACC_W'(r_integ[r_axis]);
            tapt_pkg::ACC_LOADP: n_acc = prod_x;
            tapt_pkg::ACC_ADD:   n_acc = r_acc + prod_x;
            tapt_pkg::ACC_SUBZ:  n_acc = (r_axis == tapt_pkg::AXIS_Z) ? r_acc - prod_x : r_acc;
            default:             n_acc = r_acc;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_step   = r_step;
        n_axis   = r_axis;
        load_out = 1'b0;
        if (!r_busy) begin
            if (i_in_valid) begin
                n_busy = 1'b1;
                n_step = tapt_pkg::ST_START;
                n_axis = '0;
            end
        end else begin
            n_step = tapt_pkg::STEP_W'(r_step + 1'b1);
            case (uop.jmp)
                tapt_pkg::J_UNCTRL: begin
                    if (r_axis >= AXES_LIM) begin
                        n_step = uop.target;
                    end
                end
                tapt_pkg::J_ALWAYS: begin
                    n_step = uop.target;
                end
                tapt_pkg::J_AXIS: begin
                    if (r_axis == tapt_pkg::AXIS_LAST) begin
                        n_step = tapt_pkg::ST_FINISH;
                    end else begin
                        n_axis = tapt_pkg::AXIS_W'(r_axis + 1'b1);
                        n_step = uop.target;
                    end
                end
                tapt_pkg::J_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        load_out = 1'b1;
                        n_busy   = 1'b0;
                        n_step   = tapt_pkg::ST_START;
                    end else begin
                        n_step = r_step;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_valid = load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= tapt_pkg::ST_START;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < tapt_pkg::CFG_N; i++) begin
                r_cfg[i] <= tapt_pkg::CFG_RESET[i];
            end
            for (int i = 0; i < tapt_pkg::AXIS_N; i++) begin
                r_integ[i] <= '0;
            end
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (accept && i_clear_integrators) begin
                for (int i = 0; i < tapt_pkg::AXIS_N; i++) begin
                    r_integ[i] <= '0;
                end
            end else if (r_busy && uop.wr_op == tapt_pkg::WR_INTEG) begin
                r_integ[r_axis] <= tapt_pkg::clamp_sym(r_acc, r_cfg[tapt_pkg::REG_WINDUP]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos[0]  <= i_pos_x;
            r_pos[1]  <= i_pos_y;
            r_pos[2]  <= i_pos_z;
            r_vel[0]  <= i_vel_x;
            r_vel[1]  <= i_vel_y;
            r_vel[2]  <= i_vel_z;
            r_goal[0] <= i_goal_x;
            r_goal[1] <= i_goal_y;
            r_goal[2] <= i_goal_z;
        end
        if (r_busy) begin
            r_acc <= n_acc;
            if (uop.wr_op == tapt_pkg::WR_ACCEL) begin
                r_accel <= tapt_pkg::clamp_sym(r_acc, r_cfg[tapt_pkg::REG_ACCEL_LIM]);
            end
            if (uop.wr_op == tapt_pkg::WR_FORCE) begin
                r_res[r_axis] <= tapt_pkg::sat32(r_acc);
            end
        end
        if (load_out) begin
            r_force_x <= r_res[0];
            r_force_y <= r_res[1];
            r_force_z <= r_res[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_force_x   = r_force_x;
    assign o_force_y   = r_force_y;
    assign o_force_z   = r_force_z;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && r_step == tapt_pkg::ST_START && r_axis == '0))
        else $error("request taken but sequencer did not start");

    a_load_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && r_step == tapt_pkg::ST_FINISH))
        else $error("result loaded outside the finishing step");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == tapt_pkg::ST_FINISH && r_out_valid && !i_out_ready)
        |=> (r_busy && r_step == tapt_pkg::ST_FINISH))
        else $error("finishing step left while output blocked");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_axis <= tapt_pkg::AXIS_LAST))
        else $error("axis counter out of range");
`endif

endmodule

@@ verif/three_axis_pid_thrust_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for three_axis_pid_thrust_unit: directed and random requests
// under varied flow control, each result checked against an in-bench force predictor.
// Depends on tapt_pkg and three_axis_pid_thrust_unit.
module three_axis_pid_thrust_unit_tb;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 700;
    localparam int SEGMENT_LEN  = 50;
    localparam int REPORT_MAX   = 10;

    localparam logic [tapt_pkg::CFG_W-1:0]  WORD_MAX = 31'h7fffffff;
    localparam logic [tapt_pkg::CFG_W-1:0]  ONE_Q    = 31'd65536;
    localparam logic [tapt_pkg::CFG_W-1:0]  G_EARTH  = 31'd642690;
    localparam logic [tapt_pkg::DATA_W-1:0] NEG_FULL = 32'h80000000;
    localparam logic [tapt_pkg::DATA_W-1:0] POS_FULL = 32'h7fffffff;

    typedef struct packed {
        logic [tapt_pkg::AXIS_N-1:0][tapt_pkg::DATA_W-1:0] pos;
        logic [tapt_pkg::AXIS_N-1:0][tapt_pkg::DATA_W-1:0] vel;
        logic [tapt_pkg::AXIS_N-1:0][tapt_pkg::DATA_W-1:0] goal;
        logic                                              clr;
    } t_request;

    typedef logic [tapt_pkg::AXIS_N-1:0][tapt_pkg::DATA_W-1:0] t_thrust;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [tapt_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [tapt_pkg::CFG_W-1:0]      i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            i_out_ready = 1'b0;
    t_request                        drive_req   = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic signed [tapt_pkg::DATA_W-1:0] o_force_x;
    logic signed [tapt_pkg::DATA_W-1:0] o_force_y;
    logic signed [tapt_pkg::DATA_W-1:0] o_force_z;

    logic [tapt_pkg::CFG_W-1:0] cfg_copy [tapt_pkg::CFG_N];
    longint           integ_acc [tapt_pkg::AXIS_N];
    t_thrust          thrust_expected [$];
    t_thrust          seen_thrust;
    t_thrust          want_thrust;
    string            axis_label [tapt_pkg::AXIS_N] = '{"force_x", "force_y", "force_z"};
    int               mismatch_count = 0;
    int               in_idle_pct    = 0;
    int               out_stall_pct  = 0;
    int               hold_ticket    = 0;
    int               hold_granted   = 0;
    int               hold_left      = 0;
    int               fld;

    three_axis_pid_thrust_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_pos_x             (drive_req.pos[0]),
        .i_pos_y             (drive_req.pos[1]),
        .i_pos_z             (drive_req.pos[2]),
        .i_vel_x             (drive_req.vel[0]),
        .i_vel_y             (drive_req.vel[1]),
        .i_vel_z             (drive_req.vel[2]),
        .i_goal_x            (drive_req.goal[0]),
        .i_goal_y            (drive_req.goal[1]),
        .i_goal_z            (drive_req.goal[2]),
        .i_clear_integrators (drive_req.clr),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_force_x           (o_force_x),
        .o_force_y           (o_force_y),
        .o_force_z           (o_force_z)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic longint mul_q16(input longint a, input logic [tapt_pkg::CFG_W-1:0] b);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned bw;
        bw = b;
        if (a < 0) begin
            mag = -a;
        end else begin
            mag = a;
        end
        prod = (mag * bw) >> 16;
        if (a < 0) begin
            return -longint'(prod);
        end
        return longint'(prod);
    endfunction

    function automatic longint limit_sym(input longint v,
                                         input logic [tapt_pkg::CFG_W-1:0] lim);
        longint l;
        l = lim;
        if (v > l) begin
            return l;
        end
        if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    function automatic logic [tapt_pkg::DATA_W-1:0] saturate_word(input longint v);
        if (v > 64'sd2147483647) begin
            return POS_FULL;
        end
        if (v < -64'sd2147483648) begin
            return NEG_FULL;
        end
        return v[tapt_pkg::DATA_W-1:0];
    endfunction

    function automatic t_thrust predict_thrust(input t_request r);
        longint  err;
        longint  verr;
        longint  raw;
        longint  fz;
        longint  accel [tapt_pkg::AXIS_N];
        t_thrust t;
        int      a;
        for (a = 0; a < tapt_pkg::AXIS_N; a++) begin
            if (r.clr) begin
                integ_acc[a] = 0;
            end
        end
        for (a = 0; a < tapt_pkg::AXIS_N; a++) begin
            err  = longint'($signed(r.goal[a])) - longint'($signed(r.pos[a]));
            verr = -longint'($signed(r.vel[a]));
            integ_acc[a] = limit_sym(integ_acc[a]
                                     + mul_q16(err, cfg_copy[tapt_pkg::REG_STEP_TIME]),
                                     cfg_copy[tapt_pkg::REG_WINDUP]);
            raw = mul_q16(err, cfg_copy[tapt_pkg::REG_GAIN_P])
                + mul_q16(verr, cfg_copy[tapt_pkg::REG_GAIN_D])
                + mul_q16(integ_acc[a], cfg_copy[tapt_pkg::REG_GAIN_I]);
            accel[a] = limit_sym(raw, cfg_copy[tapt_pkg::REG_ACCEL_LIM]);
            t[a] = saturate_word(mul_q16(accel[a], cfg_copy[tapt_pkg::REG_MASS]));
        end
        fz = mul_q16(accel[tapt_pkg::AXIS_Z], cfg_copy[tapt_pkg::REG_MASS])
           - mul_q16(longint'(cfg_copy[tapt_pkg::REG_MASS]), cfg_copy[tapt_pkg::REG_GRAVITY]);
        t[tapt_pkg::AXIS_Z] = saturate_word(fz);
        return t;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [tapt_pkg::DATA_W-1:0] want,
                                   input logic [tapt_pkg::DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch %s: expected %0d (0x%08h) got %0d (0x%08h)",
                     what, $signed(want), want, $signed(got), got);
        end
    endtask

    // check each result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_thrust = {o_force_z, o_force_y, o_force_x};
            if (thrust_expected.size() == 0) begin
                report_mismatch("unrequested result", 'x, seen_thrust[0]);
            end else begin
                want_thrust = thrust_expected.pop_front();
                for (fld = 0; fld < tapt_pkg::AXIS_N; fld++) begin
                    if (seen_thrust[fld] !== want_thrust[fld]) begin
                        report_mismatch(axis_label[fld], want_thrust[fld], seen_thrust[fld]);
                    end
                end
            end
        end
    end

    // hold off the output for a long stretch when asked, else stall at random
    always @(posedge i_clk) begin
        if (hold_granted != hold_ticket) begin
            hold_granted = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    task automatic load_config(input logic [tapt_pkg::CFG_W-1:0] vals [tapt_pkg::CFG_N]);
        int k;
        for (k = 0; k < tapt_pkg::CFG_N; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= tapt_pkg::CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            cfg_copy[k] = vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input t_request r);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct) @(posedge i_clk);
        end
        drive_req  <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        thrust_expected.push_back(predict_thrust(r));
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (thrust_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_request uniform_req(input logic [tapt_pkg::DATA_W-1:0] p, v, g,
                                             input logic clr);
        t_request r;
        int       a;
        for (a = 0; a < tapt_pkg::AXIS_N; a++) begin
            r.pos[a]  = p;
            r.vel[a]  = v;
            r.goal[a] = g;
        end
        r.clr = clr;
        return r;
    endfunction

    function automatic logic [tapt_pkg::DATA_W-1:0] corner_word();
        case ($urandom_range(3))
            0: return NEG_FULL;
            1: return POS_FULL;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [tapt_pkg::CFG_W-1:0] pick_word(input int unsigned typical);
        case ($urandom_range(11))
            0: return '0;
            1: return WORD_MAX;
            2: return tapt_pkg::CFG_W'($urandom());
            default: return tapt_pkg::CFG_W'($urandom_range(typical));
        endcase
    endfunction

    function automatic t_request random_request();
        t_request                           r;
        logic signed [tapt_pkg::DATA_W-1:0] ofs;
        int                                 a;
        int unsigned                        kind;
        for (a = 0; a < tapt_pkg::AXIS_N; a++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                r.pos[a]  = $signed(20'($urandom()));
                ofs       = $signed(18'($urandom()));
                r.goal[a] = r.pos[a] + ofs;
                r.vel[a]  = $signed(18'($urandom()));
            end else if (kind < 8) begin
                r.pos[a]  = $urandom();
                r.vel[a]  = $urandom();
                r.goal[a] = $urandom();
            end else if (kind == 8) begin
                r.pos[a]  = corner_word();
                r.vel[a]  = corner_word();
                r.goal[a] = corner_word();
            end else begin
                r.pos[a]  = $urandom();
                r.vel[a]  = corner_word();
                r.goal[a] = corner_word();
            end
        end
        r.clr = ($urandom_range(15) == 0);
        return r;
    endfunction

    task automatic random_config();
        logic [tapt_pkg::CFG_W-1:0] cfg [tapt_pkg::CFG_N];
        cfg[tapt_pkg::REG_STEP_TIME] = pick_word(65536);
        cfg[tapt_pkg::REG_GAIN_P]    = pick_word(1 << 20);
        cfg[tapt_pkg::REG_GAIN_I]    = pick_word(1 << 20);
        cfg[tapt_pkg::REG_GAIN_D]    = pick_word(1 << 20);
        cfg[tapt_pkg::REG_WINDUP]    = pick_word(1 << 24);
        cfg[tapt_pkg::REG_ACCEL_LIM] = pick_word(1 << 25);
        cfg[tapt_pkg::REG_MASS]      = pick_word(1 << 22);
        cfg[tapt_pkg::REG_GRAVITY]   = pick_word(1 << 20);
        load_config(cfg);
    endtask

    task automatic test_reset_defaults();
        send_request(uniform_req(NEG_FULL, POS_FULL, POS_FULL, 1'b1));
        send_request(uniform_req(POS_FULL, NEG_FULL, NEG_FULL, 1'b0));
        settle_block();
    endtask

    task automatic test_extremes();
        logic [tapt_pkg::CFG_W-1:0] cfg [tapt_pkg::CFG_N];
        t_request                   r;
        cfg[tapt_pkg::REG_STEP_TIME] = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_P]    = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_I]    = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_D]    = ONE_Q;
        cfg[tapt_pkg::REG_WINDUP]    = WORD_MAX;
        cfg[tapt_pkg::REG_ACCEL_LIM] = WORD_MAX;
        cfg[tapt_pkg::REG_MASS]      = ONE_Q;
        cfg[tapt_pkg::REG_GRAVITY]   = G_EARTH;
        load_config(cfg);
        send_request(uniform_req('0, '0, '0, 1'b1));
        send_request(uniform_req(NEG_FULL, NEG_FULL, POS_FULL, 1'b1));
        send_request(uniform_req(POS_FULL, POS_FULL, NEG_FULL, 1'b1));
        send_request(uniform_req(POS_FULL, '0, POS_FULL, 1'b0));
        r = uniform_req('1, 32'd1, '0, 1'b1);
        r.pos[1]  = 32'd1;
        r.vel[1]  = '1;
        r.pos[2]  = '0;
        r.goal[2] = NEG_FULL;
        r.vel[2]  = POS_FULL;
        send_request(r);
        settle_block();
        // tiny gains: negative fractions must round toward zero
        cfg[tapt_pkg::REG_STEP_TIME] = 31'd3;
        cfg[tapt_pkg::REG_GAIN_P]    = 31'd3;
        cfg[tapt_pkg::REG_GAIN_I]    = 31'd3;
        cfg[tapt_pkg::REG_GAIN_D]    = 31'd3;
        cfg[tapt_pkg::REG_MASS]      = 31'd40000;
        cfg[tapt_pkg::REG_GRAVITY]   = 31'd3;
        load_config(cfg);
        send_request(uniform_req(32'd65537, 32'd65537, '0, 1'b1));
        send_request(uniform_req(-32'sd65537, -32'sd65537, '0, 1'b0));
        settle_block();
    endtask

    task automatic test_saturation();
        logic [tapt_pkg::CFG_W-1:0] cfg [tapt_pkg::CFG_N];
        cfg[tapt_pkg::REG_STEP_TIME] = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_P]    = WORD_MAX;
        cfg[tapt_pkg::REG_GAIN_I]    = '0;
        cfg[tapt_pkg::REG_GAIN_D]    = WORD_MAX;
        cfg[tapt_pkg::REG_WINDUP]    = WORD_MAX;
        cfg[tapt_pkg::REG_ACCEL_LIM] = WORD_MAX;
        cfg[tapt_pkg::REG_MASS]      = WORD_MAX;
        cfg[tapt_pkg::REG_GRAVITY]   = WORD_MAX;
        load_config(cfg);
        send_request(uniform_req(NEG_FULL, NEG_FULL, POS_FULL, 1'b1));
        send_request(uniform_req(POS_FULL, POS_FULL, NEG_FULL, 1'b0));
        send_request(uniform_req('0, '0, '0, 1'b1));
        settle_block();
    endtask

    task automatic test_windup();
        logic [tapt_pkg::CFG_W-1:0] cfg [tapt_pkg::CFG_N];
        int                         n;
        cfg[tapt_pkg::REG_STEP_TIME] = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_P]    = '0;
        cfg[tapt_pkg::REG_GAIN_I]    = ONE_Q;
        cfg[tapt_pkg::REG_GAIN_D]    = '0;
        cfg[tapt_pkg::REG_WINDUP]    = 31'd655360;
        cfg[tapt_pkg::REG_ACCEL_LIM] = WORD_MAX;
        cfg[tapt_pkg::REG_MASS]      = ONE_Q;
        cfg[tapt_pkg::REG_GRAVITY]   = '0;
        load_config(cfg);
        for (n = 0; n < 4; n++) begin
            send_request(uniform_req('0, '0, 32'd262144, n == 0));
        end
        for (n = 0; n < 4; n++) begin
            send_request(uniform_req('0, '0, -32'sd262144, n == 0));
        end
        send_request(uniform_req('0, '0, 32'd196608, 1'b0));
        settle_block();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int n;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        for (n = 0; n < count; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                settle_block();
                random_config();
            end
            send_request(random_request());
        end
        settle_block();
    endtask

    task automatic test_backpressure();
        int n;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        random_config();
        hold_ticket++;
        for (n = 0; n < 30; n++) begin
            send_request(random_request());
        end
        settle_block();
    endtask

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        cfg_copy[tapt_pkg::REG_STEP_TIME] = 31'd655;
        cfg_copy[tapt_pkg::REG_GAIN_P]    = '0;
        cfg_copy[tapt_pkg::REG_GAIN_I]    = '0;
        cfg_copy[tapt_pkg::REG_GAIN_D]    = '0;
        cfg_copy[tapt_pkg::REG_WINDUP]    = '0;
        cfg_copy[tapt_pkg::REG_ACCEL_LIM] = '0;
        cfg_copy[tapt_pkg::REG_MASS]      = ONE_Q;
        cfg_copy[tapt_pkg::REG_GRAVITY]   = G_EARTH;
        integ_acc = '{0, 0, 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_saturation();
        test_windup();
        test_random_traffic(0, 0, 300);
        test_random_traffic(47, 0, 300);
        test_random_traffic(0, 47, 300);
        test_random_traffic(18, 18, 300);
        test_backpressure();
        if (mismatch_count == 0 && thrust_expected.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
